// ----- sv/icu_pkg.sv -----
// ----------------------------------------------------------------------------
// icu_pkg
// Shared types, constants and helpers of the integer calculator unit.
// ----------------------------------------------------------------------------
package icu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

    localparam logic [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] VAL_ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_QUOT = 3'd3,
        CMD_REM  = 3'd4,
        CMD_POW  = 3'd5,
        CMD_MEAN = 3'd6,
        CMD_INV  = 3'd7
    } icu_cmd_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_ERR = 2'd1,
        ST_OVF = 2'd2,
        ST_INV = 2'd3
    } icu_status_t;

    typedef struct packed {
        icu_cmd_t                      command;
        logic signed [DATA_WIDTH-1:0]  operand_a;
        logic signed [DATA_WIDTH-1:0]  operand_b;
    } icu_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  result;
        icu_status_t                   status;
    } icu_out_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_ALU_DONE,
        OP_MUL_AB,
        OP_MUL_DONE,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_POW_SQ,
        OP_POW_MUL,
        OP_POW_ACC_SQ,
        OP_POW_ACC,
        OP_POW_DONE
    } icu_op_t;

    typedef struct packed {
        icu_op_t op;
    } icu_ctrl_t;

    typedef struct packed {
        icu_cmd_t cmd;
        logic     b_zero;
        logic     b_neg;
        logic     exp_bit;
        logic     ovf;
        logic     cnt_last;
        logic     cnt_full;
    } icu_stat_t;

    function automatic logic [DATA_WIDTH-1:0] icu_mag(logic [DATA_WIDTH-1:0] x);
        return x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] icu_compose(logic [DATA_WIDTH-1:0] mag,
                                                          logic neg);
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] icu_sat(logic neg);
        return neg ? VAL_MIN : VAL_MAX;
    endfunction

endpackage

// ----- sv/integer_calculator_unit_top.sv -----
// ----------------------------------------------------------------------------
// integer_calculator_unit_top
// Signed integer calculator: add, sub, mul, quotient, remainder, power, mean.
// ----------------------------------------------------------------------------
//  port       dir   kind          meaning
//  start      in    strobe        word on request taken when busy is low
//  request    in    icu_in_t      command, operand_a, operand_b
//  busy       out   level         high while a word is in work
//  done       out   strobe        response valid for this one cycle
//  response   out   icu_out_t     result, status
//
//  add, sub, mean, invalid: operands loaded, then the result is registered from decode.
//  mul: one multiplier pass, then saturation check.
//  quotient, remainder: one quotient bit per cycle; a zero divisor skips the divider.
//  power: per exponent bit a square, and a multiply where the bit is set, through the
//  shared multiplier; a negative exponent skips the loop, overflow ends it early.
//  Reset clears the sequencer and done; the receiver cannot stall done.
// ----------------------------------------------------------------------------
module integer_calculator_unit_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  icu_pkg::icu_in_t  request,
    output logic              busy,
    output logic              done,
    output icu_pkg::icu_out_t response
);
    import icu_pkg::*;

    icu_ctrl_t ctrl;
    icu_stat_t stat;

    icu_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    icu_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .ctrl     (ctrl),
        .stat     (stat),
        .done     (done),
        .response (response)
    );

endmodule

// ----- sv/icu_controller.sv -----
// ----------------------------------------------------------------------------
// icu_controller
// Sequencer that steps the datapath through each command.
// ----------------------------------------------------------------------------
module icu_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  icu_pkg::icu_stat_t stat,
    output icu_pkg::icu_ctrl_t ctrl,
    output logic              busy
);
    import icu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_DONE,
        S_DIV,
        S_DIV_END,
        S_POW_ACC_SQ,
        S_POW_MUL,
        S_POW_ACC_MUL,
        S_POW_CHECK
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    logic    busy_reg;
    logic    busy_next;
    icu_op_t op;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        op         = OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LOAD;
                    state_next = S_DECODE;
                    busy_next  = 1'b1;
                end
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    CMD_MUL:
                    begin
                        op         = OP_MUL_AB;
                        state_next = S_MUL_DONE;
                    end
                    CMD_QUOT, CMD_REM:
                    begin
                        if (stat.b_zero)
                        begin
                            op         = OP_DIV_DONE;
                            state_next = S_IDLE;
                            busy_next  = 1'b0;
                        end
                        else
                        begin
                            op         = OP_DIV_STEP;
                            state_next = S_DIV;
                        end
                    end
                    CMD_POW:
                    begin
                        if (stat.b_neg)
                        begin
                            op         = OP_POW_DONE;
                            state_next = S_IDLE;
                            busy_next  = 1'b0;
                        end
                        else
                        begin
                            op         = OP_POW_SQ;
                            state_next = S_POW_ACC_SQ;
                        end
                    end
                    default:
                    begin
                        op         = OP_ALU_DONE;
                        state_next = S_IDLE;
                        busy_next  = 1'b0;
                    end
                endcase
            end
            S_MUL_DONE:
            begin
                op         = OP_MUL_DONE;
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
            S_DIV:
            begin
                op = OP_DIV_STEP;
                if (stat.cnt_last)
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                op         = OP_DIV_DONE;
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
            S_POW_ACC_SQ:
            begin
                op         = OP_POW_ACC_SQ;
                state_next = stat.exp_bit ? S_POW_MUL : S_POW_CHECK;
            end
            S_POW_MUL:
            begin
                op         = OP_POW_MUL;
                state_next = S_POW_ACC_MUL;
            end
            S_POW_ACC_MUL:
            begin
                op         = OP_POW_ACC;
                state_next = S_POW_CHECK;
            end
            S_POW_CHECK:
            begin
                if (stat.ovf || stat.cnt_full)
                begin
                    op         = OP_POW_DONE;
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                end
                else
                begin
                    op         = OP_POW_SQ;
                    state_next = S_POW_ACC_SQ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign ctrl.op = op;
    assign busy    = busy_reg;

endmodule

// ----- sv/icu_datapath.sv -----
// ----------------------------------------------------------------------------
// icu_datapath
// Operand registers, shared multiplier, restoring divider and result register.
// ----------------------------------------------------------------------------
module icu_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  icu_pkg::icu_in_t   request,
    input  icu_pkg::icu_ctrl_t ctrl,
    output icu_pkg::icu_stat_t stat,
    output logic               done,
    output icu_pkg::icu_out_t  response
);
    import icu_pkg::*;

    localparam int W = DATA_WIDTH;

    icu_cmd_t         cmd_reg,   cmd_next;
    logic [W-1:0]     a_reg,     a_next;
    logic [W-1:0]     b_reg,     b_next;
    logic [W-1:0]     mag_a_reg, mag_a_next;
    logic [W-1:0]     mag_b_reg, mag_b_next;
    logic             neg_reg,   neg_next;
    logic             ovf_reg,   ovf_next;
    logic [W-1:0]     acc_reg,   acc_next;
    logic [W-1:0]     rem_reg,   rem_next;
    logic [2*W-1:0]   prod_reg,  prod_next;
    logic [W-1:0]     exp_reg,   exp_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    icu_out_t         out_reg,   out_next;
    logic             done_reg,  done_next;

    logic [W-1:0]     mul_x;
    logic [W-1:0]     mul_y;
    logic [W-1:0]     lim;
    logic             prod_big;
    logic [W:0]       sum;
    logic [W:0]       diff;
    logic [W:0]       shifted;
    logic [W:0]       trial;
    logic [W-1:0]     in_mag_a;

    assign lim      = VAL_MAX + W'(neg_reg);
    assign prod_big = prod_reg > {{W{1'b0}}, lim};
    assign sum      = {a_reg[W-1], a_reg} + {b_reg[W-1], b_reg};
    assign diff     = {a_reg[W-1], a_reg} - {b_reg[W-1], b_reg};
    assign shifted  = {rem_reg, acc_reg[W-1]};
    assign trial    = shifted - {1'b0, mag_b_reg};
    assign in_mag_a = icu_mag(request.operand_a);

    always_comb
    begin
        case (ctrl.op)
            OP_POW_SQ:
            begin
                mul_x = acc_reg;
                mul_y = acc_reg;
            end
            OP_POW_MUL:
            begin
                mul_x = acc_reg;
                mul_y = mag_a_reg;
            end
            default:
            begin
                mul_x = mag_a_reg;
                mul_y = mag_b_reg;
            end
        endcase
    end

    always_comb
    begin
        cmd_next   = cmd_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        prod_next  = prod_reg;
        exp_next   = exp_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg;
        done_next  = 1'b0;
        case (ctrl.op)
            OP_LOAD:
            begin
                cmd_next   = request.command;
                a_next     = request.operand_a;
                b_next     = request.operand_b;
                mag_a_next = in_mag_a;
                mag_b_next = icu_mag(request.operand_b);
                ovf_next   = 1'b0;
                rem_next   = '0;
                exp_next   = request.operand_b;
                cnt_next   = '0;
                if (request.command == CMD_POW)
                begin
                    neg_next = request.operand_a[W-1] & request.operand_b[0];
                    acc_next = VAL_ONE;
                end
                else
                begin
                    neg_next = request.operand_a[W-1] ^ request.operand_b[W-1];
                    acc_next = in_mag_a;
                end
            end
            OP_ALU_DONE:
            begin
                done_next       = 1'b1;
                out_next.status = ST_OK;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (sum[W] != sum[W-1])
                        begin
                            out_next.result = icu_sat(sum[W]);
                            out_next.status = ST_OVF;
                        end
                        else
                        begin
                            out_next.result = sum[W-1:0];
                        end
                    end
                    CMD_SUB:
                    begin
                        if (diff[W] != diff[W-1])
                        begin
                            out_next.result = icu_sat(diff[W]);
                            out_next.status = ST_OVF;
                        end
                        else
                        begin
                            out_next.result = diff[W-1:0];
                        end
                    end
                    CMD_MEAN:
                    begin
                        out_next.result = sum[W:1] + W'(sum[W] & sum[0]);
                    end
                    default:
                    begin
                        out_next.result = '0;
                        out_next.status = ST_INV;
                    end
                endcase
            end
            OP_MUL_AB, OP_POW_SQ, OP_POW_MUL:
            begin
                prod_next = mul_x * mul_y;
            end
            OP_MUL_DONE:
            begin
                done_next = 1'b1;
                if (prod_big)
                begin
                    out_next.result = icu_sat(neg_reg);
                    out_next.status = ST_OVF;
                end
                else
                begin
                    out_next.result = icu_compose(prod_reg[W-1:0], neg_reg);
                    out_next.status = ST_OK;
                end
            end
            OP_DIV_STEP:
            begin
                if (!trial[W])
                begin
                    rem_next = trial[W-1:0];
                    acc_next = {acc_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[W-1:0];
                    acc_next = {acc_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            OP_DIV_DONE:
            begin
                done_next       = 1'b1;
                out_next.status = ST_OK;
                if (b_reg == '0)
                begin
                    out_next.result = '0;
                    out_next.status = ST_ERR;
                end
                else if (cmd_reg == CMD_REM)
                begin
                    out_next.result = icu_compose(rem_reg, a_reg[W-1]);
                end
                else if (a_reg == VAL_MIN && b_reg == '1)
                begin
                    out_next.result = VAL_MAX;
                    out_next.status = ST_OVF;
                end
                else
                begin
                    out_next.result = icu_compose(acc_reg, neg_reg);
                end
            end
            OP_POW_ACC_SQ, OP_POW_ACC:
            begin
                if (prod_big)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = prod_reg[W-1:0];
                end
                if (ctrl.op == OP_POW_ACC_SQ)
                begin
                    exp_next = {exp_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_POW_DONE:
            begin
                done_next = 1'b1;
                if (b_reg[W-1])
                begin
                    out_next.result = '0;
                    out_next.status = ST_ERR;
                end
                else if (ovf_reg)
                begin
                    out_next.result = icu_sat(neg_reg);
                    out_next.status = ST_OVF;
                end
                else
                begin
                    out_next.result = icu_compose(acc_reg, neg_reg);
                    out_next.status = ST_OK;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        neg_reg   <= neg_next;
        ovf_reg   <= ovf_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        prod_reg  <= prod_next;
        exp_reg   <= exp_next;
        cnt_reg   <= cnt_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign stat.cmd      = cmd_reg;
    assign stat.b_zero   = (b_reg == '0);
    assign stat.b_neg    = b_reg[W-1];
    assign stat.exp_bit  = exp_reg[W-1];
    assign stat.ovf      = ovf_reg;
    assign stat.cnt_last = (cnt_reg == CNT_W'(W - 1));
    assign stat.cnt_full = (cnt_reg == CNT_W'(W));

    assign done     = done_reg;
    assign response = out_reg;

endmodule

// ----- sv/icu_checker.sv -----
// ----------------------------------------------------------------------------
// icu_checker
// Port-level checks of the calculator handshake and result codes.
// ----------------------------------------------------------------------------
module icu_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input icu_pkg::icu_out_t response
);
    import icu_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (response.status == ST_ERR || response.status == ST_INV)
            |-> response.result == '0)
        else $error("nonzero result with error status");

endmodule

bind integer_calculator_unit_top icu_checker u_icu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .response (response)
);

// ----- verif/tb_integer_calculator_unit_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_calculator_unit_top
// Self-checking bench for the integer calculator unit. Directed words cover
// saturation, divide by zero, the most negative quotient, power edge cases,
// mean rounding and the invalid command. Random words then follow with
// weighted operands. Each response is compared against a behavioral
// prediction, oldest first.
// ----------------------------------------------------------------------------
module tb_integer_calculator_unit_top;
    import icu_pkg::*;

    localparam longint SAT_MAX = 64'sd2147483647;
    localparam longint SAT_MIN = -64'sd2147483648;
    localparam int     RANDOM_WORDS = 1350;

    logic      clk;
    logic      rst_n;
    logic      start;
    icu_in_t   request;
    logic      busy;
    logic      done;
    icu_out_t  response;

    icu_out_t  pending_results[$];
    int        mismatch_count;
    bit        burst_mode;

    integer_calculator_unit_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .response (response)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic icu_out_t calc_expected(icu_in_t req);
        longint      a;
        longint      b;
        longint      r;
        longint      ua;
        longint      lim;
        longint      mag;
        longint      i;
        logic        neg;
        logic        ovf;
        icu_status_t st;
        icu_out_t    o;
        a  = longint'($signed(req.operand_a));
        b  = longint'($signed(req.operand_b));
        r  = 0;
        st = ST_OK;
        case (req.command)
            CMD_ADD, CMD_SUB, CMD_MUL:
            begin
                if (req.command == CMD_ADD)
                    r = a + b;
                else if (req.command == CMD_SUB)
                    r = a - b;
                else
                    r = a * b;
                if (r > SAT_MAX)
                begin
                    r  = SAT_MAX;
                    st = ST_OVF;
                end
                else if (r < SAT_MIN)
                begin
                    r  = SAT_MIN;
                    st = ST_OVF;
                end
            end
            CMD_QUOT:
            begin
                if (b == 0)
                    st = ST_ERR;
                else
                begin
                    r = a / b;
                    if (r > SAT_MAX)
                    begin
                        r  = SAT_MAX;
                        st = ST_OVF;
                    end
                end
            end
            CMD_REM:
            begin
                if (b == 0)
                    st = ST_ERR;
                else
                    r = a % b;
            end
            CMD_POW:
            begin
                if (b < 0)
                    st = ST_ERR;
                else if (b == 0)
                    r = 1;
                else
                begin
                    neg = (a < 0) && b[0];
                    ua  = (a < 0) ? -a : a;
                    if (ua <= 1)
                        r = neg ? -ua : ua;
                    else
                    begin
                        lim = neg ? SAT_MAX + 1 : SAT_MAX;
                        mag = 1;
                        ovf = 1'b0;
                        i   = 0;
                        while (i < b && !ovf)
                        begin
                            if (mag > lim / ua)
                                ovf = 1'b1;
                            else
                                mag = mag * ua;
                            i = i + 1;
                        end
                        if (ovf)
                        begin
                            r  = neg ? SAT_MIN : SAT_MAX;
                            st = ST_OVF;
                        end
                        else
                            r = neg ? -mag : mag;
                    end
                end
            end
            CMD_MEAN:
                r = (a + b) / 2;
            default:
                st = ST_INV;
        endcase
        o.result = r[DATA_WIDTH-1:0];
        o.status = st;
        return o;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 9);
        if (burst_mode || sel < 5)
            return 0;
        if (sel < 8)
            return $urandom_range(1, 3);
        if (sel < 9)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return $urandom_range(0, 2) - 1;
            3:       return VAL_MAX - $urandom_range(0, 3);
            4:       return VAL_MIN + $urandom_range(0, 3);
            5, 6:    return $urandom_range(0, 200) - 100;
            7:       return (32'd1 << $urandom_range(0, 31)) * ($urandom_range(0, 1) ? 1 : -1);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // hold start until the word is taken, then idle for a random gap
    task automatic issue(input icu_cmd_t cmd, input logic [DATA_WIDTH-1:0] a,
                         input logic [DATA_WIDTH-1:0] b);
        icu_in_t word;
        int      gap;
        word.command   = cmd;
        word.operand_a = a;
        word.operand_b = b;
        @(negedge clk);
        start   <= 1'b1;
        request <= word;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(calc_expected(word));
        gap = pick_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        icu_out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("response with no word pending");
            else
            begin
                want = pending_results.pop_front();
                if (response.result !== want.result)
                    report_mismatch($sformatf("result %0d, want %0d",
                                              response.result, want.result));
                if (response.status !== want.status)
                    report_mismatch($sformatf("status %s, want %s",
                                              response.status.name(), want.status.name()));
            end
        end
    end

    task automatic test_add_sub();
        issue(CMD_ADD, VAL_MAX, 32'd1);
        issue(CMD_ADD, VAL_MIN, -32'sd1);
        issue(CMD_ADD, 32'd1234, -32'sd5678);
        issue(CMD_SUB, VAL_MIN, 32'd1);
        issue(CMD_SUB, VAL_MAX, -32'sd1);
        issue(CMD_SUB, -32'sd1, VAL_MAX);
    endtask

    task automatic test_mul();
        issue(CMD_MUL, VAL_MAX, 32'd2);
        issue(CMD_MUL, VAL_MIN, -32'sd1);
        issue(CMD_MUL, -32'sd65536, 32'd32768);
        issue(CMD_MUL, 32'd65536, 32'd32768);
    endtask

    task automatic test_divide();
        issue(CMD_QUOT, 32'd7, 32'd0);
        issue(CMD_QUOT, VAL_MIN, -32'sd1);
        issue(CMD_QUOT, -32'sd7, 32'd2);
        issue(CMD_REM, 32'd5, 32'd0);
        issue(CMD_REM, VAL_MIN, -32'sd1);
        issue(CMD_REM, -32'sd7, 32'd3);
        issue(CMD_REM, 32'd7, -32'sd3);
    endtask

    task automatic test_power();
        issue(CMD_POW, 32'd0, 32'd0);
        issue(CMD_POW, 32'd5, -32'sd1);
        issue(CMD_POW, 32'd2, 32'd30);
        issue(CMD_POW, 32'd2, 32'd31);
        issue(CMD_POW, -32'sd2, 32'd31);
        issue(CMD_POW, -32'sd3, 32'd21);
        issue(CMD_POW, -32'sd1, VAL_MAX);
    endtask

    task automatic test_mean_invalid();
        issue(CMD_MEAN, VAL_MAX, VAL_MAX);
        issue(CMD_MEAN, VAL_MIN, VAL_MIN);
        issue(CMD_MEAN, -32'sd3, 32'd0);
        issue(CMD_MEAN, VAL_MIN, VAL_MAX);
        issue(CMD_INV, VAL_MAX, VAL_MIN);
    endtask

    task automatic test_random();
        icu_cmd_t               cmd;
        logic [DATA_WIDTH-1:0]  a;
        logic [DATA_WIDTH-1:0]  b;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            burst_mode = ((n / 100) % 4) == 3;
            cmd = icu_cmd_t'($urandom_range(0, 7));
            a   = pick_operand();
            b   = pick_operand();
            if (cmd == CMD_POW)
            begin
                if ($urandom_range(0, 3) != 0)
                    a = $urandom_range(0, 40) - 20;
                if ($urandom_range(0, 4) != 0)
                    b = $urandom_range(0, 40);
            end
            else if ((cmd == CMD_QUOT || cmd == CMD_REM) && $urandom_range(0, 9) == 0)
                b = $urandom_range(0, 1) ? 32'd0 : -32'sd1;
            issue(cmd, a, b);
        end
        burst_mode = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        mismatch_count = 0;
        burst_mode     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_add_sub();
        test_mul();
        test_divide();
        test_power();
        test_mean_invalid();
        test_random();

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4 * DATA_WIDTH + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/icu_pkg.sv
sv/icu_controller.sv
sv/icu_datapath.sv
sv/integer_calculator_unit_top.sv
sv/icu_checker.sv
verif/tb_integer_calculator_unit_top.sv
